// ===== rtl/rhpg_pkg.sv =====
// Package with shared constants, register indexes and control types of the rainbow generator.
package rhpg_pkg;

	localparam int LEDS      = 16;
	localparam int LED_IDX_W = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam int CNT_W     = 16;

	localparam logic [LED_IDX_W-1:0] LAST_LED_IDX = LED_IDX_W'(LEDS - 1);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HUE_STEP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LED_HUE_STEP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SATURATION     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VALUE_LEVEL    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES_TOTAL   = 3'd4;

	// Reset values of the configuration registers.
	localparam logic [7:0]       RST_FRAME_HUE_STEP = 8'd5;
	localparam logic [7:0]       RST_LED_HUE_STEP   = 8'd85;
	localparam logic [7:0]       RST_SATURATION     = 8'd255;
	localparam logic [7:0]       RST_VALUE_LEVEL    = 8'd50;
	localparam logic [CNT_W-1:0] RST_FRAMES_TOTAL   = 16'd250;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} rhpg_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;  // frame tick transfer: latch counter and base hue
		logic issue;  // push the next LED into the color pipeline
	} rhpg_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic adv;       // color pipeline moves this cycle
		logic last_idx;  // LED being issued is the final one of the frame
	} rhpg_sts_t;

endpackage

// ===== rtl/rhpg_tick_if.sv =====
// Frame tick channel carrying the restart flag.
interface rhpg_tick_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

// ===== rtl/rhpg_pixel_if.sv =====
// Pixel result channel carrying one LED color per transfer.
interface rhpg_pixel_if;
	logic                            valid;
	logic                            ready;
	logic [rhpg_pkg::LED_IDX_W-1:0]  led_index;
	logic [7:0]                      red;
	logic [7:0]                      green;
	logic [7:0]                      blue;
	logic                            last_led;

	modport source (output valid, output led_index, output red, output green,
		output blue, output last_led, input ready);
	modport sink   (input valid, input led_index, input red, input green,
		input blue, input last_led, output ready);
endinterface

// ===== rtl/rhpg_cfg_if.sv =====
// Configuration write channel with register index and write data.
interface rhpg_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [rhpg_pkg::CFG_IDX_W-1:0]  index;
	logic [rhpg_pkg::CFG_DAT_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/rhpg_ctrl.sv =====
// Controller state machine that sequences the LEDs of one frame.
module rhpg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick_valid,
	output logic                tick_ready,
	input  rhpg_pkg::rhpg_sts_t sts,
	output rhpg_pkg::rhpg_cmd_t cmd
);
	import rhpg_pkg::*;

	rhpg_state_t state_q;
	rhpg_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (tick_valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (sts.adv && sts.last_idx) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		tick_ready = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				tick_ready = 1'b1;
				cmd.start  = tick_valid;
			end
			ST_RUN: begin
				cmd.issue = sts.adv;
			end
			default: begin
				tick_ready = 1'b0;
			end
		endcase
	end

	// A frame never starts while LEDs of the current one are still being issued.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !cmd.issue && state_q == ST_IDLE)
		else $error("frame start while issuing");

	// After the final LED is issued the controller is back to taking ticks.
	a_last_returns: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue && sts.last_idx |=> tick_ready)
		else $error("controller did not return to idle after last LED");

	// Issue always lines up with pipeline movement.
	a_issue_adv: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> sts.adv && state_q == ST_RUN)
		else $error("issue without pipeline advance");

endmodule

// ===== rtl/rhpg_datapath.sv =====
// Datapath: configuration registers, frame counter, hue stepping and HSV-to-RGB pipeline.
module rhpg_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                restart,
	input  rhpg_pkg::rhpg_cmd_t cmd,
	output rhpg_pkg::rhpg_sts_t sts,
	rhpg_cfg_if.sink            cfg,
	rhpg_pixel_if.source        pixel
);
	import rhpg_pkg::*;

	// Configuration registers.
	logic [7:0]       frame_step_q;
	logic [7:0]       led_step_q;
	logic [7:0]       sat_q;
	logic [7:0]       val_q;
	logic [CNT_W-1:0] frames_total_q;

	// Frame state.
	logic [CNT_W-1:0]     frame_cnt_q;
	logic [7:0]           hue_q;
	logic [LED_IDX_W-1:0] idx_q;
	logic                 active_q;

	// Pipeline.
	logic                 valid_s1, valid_s2, valid_s3, out_valid_q;
	logic [7:0]           hue_s1;
	logic [LED_IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	logic                 active_s1, active_s2, active_s3;
	logic                 last_s1, last_s2, last_s3;
	logic [2:0]           region_s2, region_s3;
	logic [7:0]           rem_s2;
	logic [7:0]           sr_s3, st_s3, p_s3;

	logic                 adv;
	logic [CNT_W-1:0]     cnt_eff;
	logic                 active_eff;
	logic [15:0]          base_prod;
	logic [2:0]           region_c;
	logic [7:0]           region_base_c;
	logic [7:0]           diff_c;
	logic [15:0]          sr_prod, st_prod, p_prod, q_prod, t_prod;
	logic [7:0]           q_c, t_c;
	logic [7:0]           r_c, g_c, b_c;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_step_q   <= RST_FRAME_HUE_STEP;
			led_step_q     <= RST_LED_HUE_STEP;
			sat_q          <= RST_SATURATION;
			val_q          <= RST_VALUE_LEVEL;
			frames_total_q <= RST_FRAMES_TOTAL;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FRAME_HUE_STEP: frame_step_q   <= cfg.data[7:0];
				REG_LED_HUE_STEP:   led_step_q     <= cfg.data[7:0];
				REG_SATURATION:     sat_q          <= cfg.data[7:0];
				REG_VALUE_LEVEL:    val_q          <= cfg.data[7:0];
				REG_FRAMES_TOTAL:   frames_total_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Frame start: only the low byte of the count matters for the hue.
	assign cnt_eff    = restart ? '0 : frame_cnt_q;
	assign active_eff = cnt_eff < frames_total_q;
	assign base_prod  = cnt_eff[7:0] * frame_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cnt_q <= '0;
		end else if (cmd.start) begin
			frame_cnt_q <= active_eff ? CNT_W'(cnt_eff + 1'b1) : cnt_eff;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hue_q    <= base_prod[7:0];
			idx_q    <= '0;
			active_q <= active_eff;
		end else if (cmd.issue) begin
			hue_q <= hue_q + led_step_q;
			idx_q <= idx_q + 1'b1;
		end
	end

	assign adv          = !out_valid_q || pixel.ready;
	assign sts.adv      = adv;
	assign sts.last_idx = idx_q == LAST_LED_IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= cmd.issue;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	// Stage 1 logic: six hue regions, each 43 wide but the last, which is 41 wide.
	always_comb begin
		if (hue_s1 >= 8'd215) begin
			region_c = 3'd5;
		end else if (hue_s1 >= 8'd172) begin
			region_c = 3'd4;
		end else if (hue_s1 >= 8'd129) begin
			region_c = 3'd3;
		end else if (hue_s1 >= 8'd86) begin
			region_c = 3'd2;
		end else if (hue_s1 >= 8'd43) begin
			region_c = 3'd1;
		end else begin
			region_c = 3'd0;
		end
		region_base_c = 8'(region_c * 8'd43);
		diff_c        = hue_s1 - region_base_c;
	end

	// Stage 2 logic: saturation products.
	assign sr_prod = sat_q * rem_s2;
	assign st_prod = sat_q * (8'd255 - rem_s2);
	assign p_prod  = val_q * (8'd255 - sat_q);

	// Stage 3 logic: value products and channel selection.
	assign q_prod = val_q * (8'd255 - sr_s3);
	assign t_prod = val_q * (8'd255 - st_s3);
	assign q_c    = q_prod[15:8];
	assign t_c    = t_prod[15:8];

	always_comb begin
		case (region_s3)
			3'd0:    begin r_c = val_q; g_c = t_c;   b_c = p_s3;  end
			3'd1:    begin r_c = q_c;   g_c = val_q; b_c = p_s3;  end
			3'd2:    begin r_c = p_s3;  g_c = val_q; b_c = t_c;   end
			3'd3:    begin r_c = p_s3;  g_c = q_c;   b_c = val_q; end
			3'd4:    begin r_c = t_c;   g_c = p_s3;  b_c = val_q; end
			default: begin r_c = val_q; g_c = p_s3;  b_c = q_c;   end
		endcase
		if (sat_q == 8'd0) begin
			r_c = val_q;
			g_c = val_q;
			b_c = val_q;
		end
		if (!active_s3) begin
			r_c = 8'd0;
			g_c = 8'd0;
			b_c = 8'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hue_s1    <= hue_q;
			idx_s1    <= idx_q;
			active_s1 <= active_q;
			last_s1   <= idx_q == LAST_LED_IDX;

			region_s2 <= region_c;
			rem_s2    <= 8'(diff_c * 8'd6);
			idx_s2    <= idx_s1;
			active_s2 <= active_s1;
			last_s2   <= last_s1;

			region_s3 <= region_s2;
			sr_s3     <= sr_prod[15:8];
			st_s3     <= st_prod[15:8];
			p_s3      <= p_prod[15:8];
			idx_s3    <= idx_s2;
			active_s3 <= active_s2;
			last_s3   <= last_s2;

			pixel.led_index <= idx_s3;
			pixel.red       <= r_c;
			pixel.green     <= g_c;
			pixel.blue      <= b_c;
			pixel.last_led  <= last_s3;
		end
	end

	assign pixel.valid = out_valid_q;

	// The last-LED flag only ever goes with the final LED index.
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && pixel.last_led |-> pixel.led_index == LAST_LED_IDX)
		else $error("last_led on wrong index");

	// A stalled pipeline keeps its final stage occupied.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !adv |=> valid_s3)
		else $error("stage three lost an LED during stall");

	// A new frame's first LED is issued with index zero.
	a_first_index: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> idx_q == '0)
		else $error("LED index not cleared at frame start");

endmodule

// ===== rtl/rainbow_hsv_pixel_generator.sv =====
// Top level of the rainbow HSV pixel generator: controller and datapath.
// The first LED color of a frame passes the hue and index registers, stages 1 to 3 and
// the output register before it is offered. One LED per cycle while the pixel sink is
// ready; a frame has 16 LEDs, and the next tick is taken once the final LED is issued.
// Reset (arst_n low, asynchronous): frame counter cleared, registers at their defaults,
// pipeline emptied, no pixel offered.
module rainbow_hsv_pixel_generator (
	input  logic          clk,
	input  logic          arst_n,
	rhpg_tick_if.sink     tick,
	rhpg_pixel_if.source  pixel,
	rhpg_cfg_if.sink      cfg
);
	import rhpg_pkg::*;

	// Command and status between the sequencer and the color pipeline.
	rhpg_cmd_t cmd;
	rhpg_sts_t sts;

	// The controller takes a tick transfer only when idle, then walks the
	// LED index forward one step per cycle the pipeline can move.
	rhpg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick.valid),
		.tick_ready (tick.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// The datapath holds the configuration, the frame counter and the
	// three-stage hue-to-RGB pipeline with its output register.
	rhpg_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (tick.restart),
		.cmd     (cmd),
		.sts     (sts),
		.cfg     (cfg),
		.pixel   (pixel)
	);

endmodule
